// File: src/acfc_pkg.sv
// Package for the arc centre block: shared widths, the multiplier latency and the
// state record handed along the long-division cell row. No dependencies.
`timescale 1ns / 1ps

package acfc_pkg;

  localparam int unsigned RAD_W   = 31;
  localparam int unsigned NUM_W   = 2 * RAD_W + 2;
  localparam int unsigned ROOT_W  = NUM_W / 2;
  localparam int unsigned MUL_LAT = 3;

  localparam logic [RAD_W-1:0] RAD_MAX = '1;

  typedef struct packed {
    logic [NUM_W-1:0] rem;
    logic [NUM_W-1:0] nq;
    logic [NUM_W-1:0] dvs;
  } div_t;

endpackage

// File: src/acfc_mul.sv
// Pipelined unsigned multiplier built from four half-width partial products.
// Three register stages; stand-alone, no package needed.
`timescale 1ns / 1ps

module acfc_mul #(
  parameter int unsigned W = 32
) (
  input  logic           clk_i,
  input  logic           en_i,
  input  logic [W-1:0]   a_i,
  input  logic [W-1:0]   b_i,
  output logic [2*W-1:0] p_o
);

  localparam int unsigned LW = (W + 1) / 2;
  localparam int unsigned HW = W - LW;

  logic [2*LW-1:0] ll_q, lo2_q;
  logic [W-1:0]    lh_q, hl_q;
  logic [2*HW-1:0] hh_q, hi2_q;
  logic [W:0]      mid_q;
  logic [2*W-1:0]  p_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ll_q  <= a_i[LW-1:0] * b_i[LW-1:0];
      lh_q  <= a_i[LW-1:0] * b_i[W-1:LW];
      hl_q  <= a_i[W-1:LW] * b_i[LW-1:0];
      hh_q  <= a_i[W-1:LW] * b_i[W-1:LW];
      mid_q <= (W+1)'(lh_q) + (W+1)'(hl_q);
      lo2_q <= ll_q;
      hi2_q <= hh_q;
      p_q   <= {hi2_q, lo2_q} + (2*W)'({mid_q, {LW{1'b0}}});
    end
  end

  assign p_o = p_q;

endmodule

// File: src/acfc_div_cell.sv
// One restoring long-division step: shifts in a numerator bit, subtracts the
// divisor where it fits and records the quotient bit. Uses acfc_pkg.
`timescale 1ns / 1ps

module acfc_div_cell
  import acfc_pkg::*;
(
  input  logic clk_i,
  input  logic en_i,
  input  div_t st_i,
  output div_t st_o
);

  logic [NUM_W:0] t;
  logic [NUM_W:0] diff;
  logic           ge;
  div_t           st_q;

  assign t    = {st_i.rem, st_i.nq[NUM_W-1]};
  assign diff = t - {1'b0, st_i.dvs};
  assign ge   = t >= {1'b0, st_i.dvs};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_q.rem <= ge ? diff[NUM_W-1:0] : t[NUM_W-1:0];
      st_q.nq  <= {st_i.nq[NUM_W-2:0], ge};
      st_q.dvs <= st_i.dvs;
    end
  end

  assign st_o = st_q;

endmodule

// File: src/acfc_sqrt_cell.sv
// One digit step of a restoring integer square root, two radicand bits per
// cell. Stand-alone, no package needed.
`timescale 1ns / 1ps

module acfc_sqrt_cell #(
  parameter int unsigned NW = 64
) (
  input  logic              clk_i,
  input  logic              en_i,
  input  logic [NW-1:0]     rad_i,
  input  logic [NW/2+1:0]   rem_i,
  input  logic [NW/2-1:0]   root_i,
  output logic [NW/2-1:0]   root_o,
  output logic [NW/2+1:0]   rem_o,
  output logic [NW-1:0]     rad_o
);

  localparam int unsigned HW = NW / 2;

  logic [HW+3:0] t, trial, diff;
  logic          ge;
  logic [NW-1:0] rad_q;
  logic [HW+1:0] rem_q;
  logic [HW-1:0] root_q;

  assign t     = {rem_i, rad_i[NW-1:NW-2]};
  assign trial = {2'b00, root_i, 2'b01};
  assign diff  = t - trial;
  assign ge    = t >= trial;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rad_q  <= {rad_i[NW-3:0], 2'b00};
      rem_q  <= ge ? diff[HW+1:0] : t[HW+1:0];
      root_q <= {root_i[HW-2:0], ge};
    end
  end

  assign rad_o  = rad_q;
  assign rem_o  = rem_q;
  assign root_o = root_q;

endmodule

// File: src/acfc_dly.sv
// Fixed-length register delay line with a shared advance enable.
// Stand-alone, no package needed.
`timescale 1ns / 1ps

module acfc_dly #(
  parameter int unsigned W = 8,
  parameter int unsigned N = 2
) (
  input  logic         clk_i,
  input  logic         en_i,
  input  logic [W-1:0] d_i,
  output logic [W-1:0] q_o
);

  logic [W-1:0] tap_q [N];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tap_q[0] <= d_i;
      for (int k = 1; k < N; k++) begin
        tap_q[k] <= tap_q[k-1];
      end
    end
  end

  assign q_o = tap_q[N-1];

endmodule

// File: src/arc_center_from_chord_radius.sv
// Arc centre from chord and radius: top level. Uses acfc_pkg, acfc_mul,
// acfc_div_cell, acfc_sqrt_cell and acfc_dly.
//
// The block accepts one arc per clock cycle unless stalled, and presents
// its result on the output after a pipeline whose depth does not depend on
// the coordinate width. The depth is set by the row of 64 long-division cells
// followed by the row of 32 square-root cells that produce each perpendicular
// offset; the squares and the products ahead of them are split multipliers of
// three stages each. The whole row advances together, and holds only while a
// result waits at the output and the last stage is also full.
`timescale 1ns / 1ps

module arc_center_from_chord_radius
  import acfc_pkg::*;
#(
  parameter int unsigned COORD_BITS = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [COORD_BITS-1:0] start_x_i,
  input  logic [COORD_BITS-1:0] start_y_i,
  input  logic [COORD_BITS-1:0] end_x_i,
  input  logic [COORD_BITS-1:0] end_y_i,
  input  logic [RAD_W-1:0]      arc_radius_i,
  input  logic                  turn_dir_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [COORD_BITS-1:0] center_x_o,
  output logic [COORD_BITS-1:0] center_y_o,
  output logic [RAD_W-1:0]      used_radius_o,
  output logic                  radius_clamped_o
);

  localparam int unsigned C    = COORD_BITS;
  localparam int unsigned DW   = 2 * C + 2;
  localparam int unsigned KW   = (DW > NUM_W) ? DW : NUM_W;
  localparam int unsigned TW   = ((C + 1 > ROOT_W + 1) ? C + 1 : ROOT_W + 1) + 2;
  localparam int unsigned SW   = TW + 1;
  localparam int unsigned UW   = (C + 1 > RAD_W) ? C + 1 : RAD_W;
  localparam int unsigned SBW  = 2 * (C + 1) + 2 * C + RAD_W + 1 + 2 * (C + 2);

  localparam int unsigned ST_IN = 1;
  localparam int unsigned ST_H  = ST_IN + MUL_LAT + 2;
  localparam int unsigned ST_N  = ST_H + MUL_LAT;
  localparam int unsigned ST_Q  = ST_N + NUM_W;
  localparam int unsigned ST_R  = ST_Q + ROOT_W;
  localparam int unsigned ST_F  = ST_R + 1;

  localparam logic signed [SW-1:0] CMAX = {{(SW-C+1){1'b0}}, {(C-1){1'b1}}};
  localparam logic signed [SW-1:0] CMIN = {{(SW-C+1){1'b1}}, {(C-1){1'b0}}};

  logic              adv;
  logic [ST_F:1]     vld_q;

  logic signed [C:0] dx_d, dy_d;
  logic [C:0]        ax_d, ay_d, ax_q, ay_q;
  logic [C+1:0]      msx_d, msy_d;
  logic [RAD_W-1:0]  r_q;
  logic [SBW-1:0]    sb_q, sb_r;

  logic [DW-1:0]        ax2, ay2, d_q, dh_q;
  logic [2*RAD_W-1:0]   r2;
  logic [NUM_W-1:0]     r4_q, ax2_q, ay2_q, ax2h_q, ay2h_q, h_q, dlo_q, dvs_n;
  logic                 clamp_q, clamp_r;
  logic [2*NUM_W-1:0]   numx, numy;

  div_t divx [NUM_W+1];
  div_t divy [NUM_W+1];

  logic [NUM_W-1:0]  radx [ROOT_W+1];
  logic [ROOT_W+1:0] remx [ROOT_W+1];
  logic [ROOT_W-1:0] rootx [ROOT_W+1];
  logic [NUM_W-1:0]  rady [ROOT_W+1];
  logic [ROOT_W+1:0] remy [ROOT_W+1];
  logic [ROOT_W-1:0] rooty [ROOT_W+1];

  logic [DW-1:0]     radd [C+2];
  logic [C+2:0]      remd [C+2];
  logic [C:0]        rootd [C+2];
  logic [C:0]        rootd_r;

  logic signed [C:0]   sb_dx, sb_dy;
  logic signed [C-1:0] sb_sx, sb_sy;
  logic [RAD_W-1:0]    sb_rad;
  logic                sb_dir;
  logic [C+1:0]        sb_msx, sb_msy;

  logic signed [TW-1:0] dxe, dye, wxe, wye, oxe, oye, tx_d, ty_d, tx_q, ty_q;
  logic signed [C-1:0]  sx_q, sy_q;
  logic [C+1:0]         msx_q, msy_q;
  logic [RAD_W-1:0]     rf_q;
  logic                 clf_q;
  logic [C:0]           rd_q;

  logic signed [SW-1:0] sumx, sumy;
  logic [C+1:0]         mqx, mqy, urw;
  logic [C-1:0]         cx_d, cy_d;
  logic [RAD_W-1:0]     ur_d;

  logic                 out_valid_q;
  logic [C-1:0]         cx_q, cy_q;
  logic [RAD_W-1:0]     ur_q;
  logic                 cl_q;

  assign adv        = !(vld_q[ST_F] && out_valid_q && out_stall_i);
  assign in_stall_o = !adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[ST_F-1:1], in_valid_i};
    end
  end

  always_comb begin
    dx_d  = {end_x_i[C-1], end_x_i} - {start_x_i[C-1], start_x_i};
    dy_d  = {end_y_i[C-1], end_y_i} - {start_y_i[C-1], start_y_i};
    ax_d  = dx_d[C] ? -dx_d : dx_d;
    ay_d  = dy_d[C] ? -dy_d : dy_d;
    msx_d = {{2{start_x_i[C-1]}}, start_x_i} + {{2{end_x_i[C-1]}}, end_x_i} + (C+2)'(1);
    msy_d = {{2{start_y_i[C-1]}}, start_y_i} + {{2{end_y_i[C-1]}}, end_y_i} + (C+2)'(1);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ax_q <= ax_d;
      ay_q <= ay_d;
      r_q  <= arc_radius_i;
      sb_q <= {dx_d, dy_d, start_x_i, start_y_i, arc_radius_i, turn_dir_i, msx_d, msy_d};
    end
  end

  acfc_mul #(.W(C + 1)) u_mul_ax (
    .clk_i(clk_i), .en_i(adv), .a_i(ax_q), .b_i(ax_q), .p_o(ax2)
  );
  acfc_mul #(.W(C + 1)) u_mul_ay (
    .clk_i(clk_i), .en_i(adv), .a_i(ay_q), .b_i(ay_q), .p_o(ay2)
  );
  acfc_mul #(.W(RAD_W)) u_mul_r (
    .clk_i(clk_i), .en_i(adv), .a_i(r_q), .b_i(r_q), .p_o(r2)
  );

  always_ff @(posedge clk_i) begin
    if (adv) begin
      d_q     <= ax2 + ay2;
      r4_q    <= {r2, 2'b00};
      ax2_q   <= NUM_W'(ax2);
      ay2_q   <= NUM_W'(ay2);
      clamp_q <= (d_q == '0) || (KW'(r4_q) <= KW'(d_q));
      h_q     <= r4_q - NUM_W'(d_q);
      dlo_q   <= NUM_W'(d_q);
      dh_q    <= d_q;
      ax2h_q  <= ax2_q;
      ay2h_q  <= ay2_q;
    end
  end

  acfc_mul #(.W(NUM_W)) u_mul_nx (
    .clk_i(clk_i), .en_i(adv), .a_i(ay2h_q), .b_i(h_q), .p_o(numx)
  );
  acfc_mul #(.W(NUM_W)) u_mul_ny (
    .clk_i(clk_i), .en_i(adv), .a_i(ax2h_q), .b_i(h_q), .p_o(numy)
  );
  acfc_dly #(.W(NUM_W), .N(MUL_LAT)) u_dly_dvs (
    .clk_i(clk_i), .en_i(adv), .d_i(dlo_q), .q_o(dvs_n)
  );

  assign divx[0] = '{rem: numx[2*NUM_W-1:NUM_W], nq: numx[NUM_W-1:0], dvs: dvs_n};
  assign divy[0] = '{rem: numy[2*NUM_W-1:NUM_W], nq: numy[NUM_W-1:0], dvs: dvs_n};

  for (genvar i = 0; i < NUM_W; i++) begin : g_div
    acfc_div_cell u_dx (.clk_i(clk_i), .en_i(adv), .st_i(divx[i]), .st_o(divx[i+1]));
    acfc_div_cell u_dy (.clk_i(clk_i), .en_i(adv), .st_i(divy[i]), .st_o(divy[i+1]));
  end

  assign radx[0]  = divx[NUM_W].nq;
  assign remx[0]  = '0;
  assign rootx[0] = '0;
  assign rady[0]  = divy[NUM_W].nq;
  assign remy[0]  = '0;
  assign rooty[0] = '0;

  for (genvar i = 0; i < ROOT_W; i++) begin : g_root
    acfc_sqrt_cell #(.NW(NUM_W)) u_sx (
      .clk_i(clk_i), .en_i(adv), .rad_i(radx[i]), .rem_i(remx[i]), .root_i(rootx[i]),
      .root_o(rootx[i+1]), .rem_o(remx[i+1]), .rad_o(radx[i+1])
    );
    acfc_sqrt_cell #(.NW(NUM_W)) u_sy (
      .clk_i(clk_i), .en_i(adv), .rad_i(rady[i]), .rem_i(remy[i]), .root_i(rooty[i]),
      .root_o(rooty[i+1]), .rem_o(remy[i+1]), .rad_o(rady[i+1])
    );
  end

  assign radd[0]  = dh_q;
  assign remd[0]  = '0;
  assign rootd[0] = '0;

  for (genvar i = 0; i < C + 1; i++) begin : g_chord
    acfc_sqrt_cell #(.NW(DW)) u_sd (
      .clk_i(clk_i), .en_i(adv), .rad_i(radd[i]), .rem_i(remd[i]), .root_i(rootd[i]),
      .root_o(rootd[i+1]), .rem_o(remd[i+1]), .rad_o(radd[i+1])
    );
  end

  acfc_dly #(.W(C + 1), .N(ST_R - ST_H - C - 1)) u_dly_chord (
    .clk_i(clk_i), .en_i(adv), .d_i(rootd[C+1]), .q_o(rootd_r)
  );
  acfc_dly #(.W(1), .N(ST_R - ST_H)) u_dly_clamp (
    .clk_i(clk_i), .en_i(adv), .d_i(clamp_q), .q_o(clamp_r)
  );
  acfc_dly #(.W(SBW), .N(ST_R - ST_IN)) u_dly_sb (
    .clk_i(clk_i), .en_i(adv), .d_i(sb_q), .q_o(sb_r)
  );

  assign {sb_dx, sb_dy, sb_sx, sb_sy, sb_rad, sb_dir, sb_msx, sb_msy} = sb_r;

  always_comb begin
    dxe  = TW'(sb_dx);
    dye  = TW'(sb_dy);
    wxe  = TW'(rootx[ROOT_W]);
    wye  = TW'(rooty[ROOT_W]);
    oxe  = (sb_dy == '0) ? '0 : (((sb_dy > 0) ^ sb_dir) ? -wxe : wxe);
    oye  = (sb_dx == '0) ? '0 : (((sb_dx < 0) ^ sb_dir) ? -wye : wye);
    tx_d = dxe + oxe + TW'(1);
    ty_d = dye + oye + TW'(1);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      tx_q  <= tx_d;
      ty_q  <= ty_d;
      sx_q  <= sb_sx;
      sy_q  <= sb_sy;
      msx_q <= sb_msx;
      msy_q <= sb_msy;
      rf_q  <= sb_rad;
      clf_q <= clamp_r;
      rd_q  <= rootd_r;
    end
  end

  always_comb begin
    sumx = SW'(sx_q) + SW'(tx_q >>> 1);
    sumy = SW'(sy_q) + SW'(ty_q >>> 1);
    mqx  = msx_q + {{(C+1){1'b0}}, msx_q[C+1]};
    mqy  = msy_q + {{(C+1){1'b0}}, msy_q[C+1]};
    urw  = {1'b0, rd_q} + (C+2)'(1);
    if (clf_q) begin
      cx_d = mqx[C:1];
      cy_d = mqy[C:1];
      ur_d = (UW'(urw[C+1:1]) > UW'(RAD_MAX)) ? RAD_MAX : RAD_W'(urw[C+1:1]);
    end else begin
      cx_d = (sumx > CMAX) ? CMAX[C-1:0] : ((sumx < CMIN) ? CMIN[C-1:0] : sumx[C-1:0]);
      cy_d = (sumy > CMAX) ? CMAX[C-1:0] : ((sumy < CMIN) ? CMIN[C-1:0] : sumy[C-1:0]);
      ur_d = rf_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || !out_stall_i) begin
      out_valid_q <= vld_q[ST_F];
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || !out_stall_i) begin
      cx_q <= cx_d;
      cy_q <= cy_d;
      ur_q <= ur_d;
      cl_q <= clf_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign center_x_o       = cx_q;
  assign center_y_o       = cy_q;
  assign used_radius_o    = ur_q;
  assign radius_clamped_o = cl_q;

  a_full_blocks_input : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (vld_q[ST_F] && out_valid_o && out_stall_i) |-> in_stall_o
  ) else $error("Input taken while the last stage could not drain.");

  a_transfer_enters : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> vld_q[1]
  ) else $error("Accepted transfer did not enter the first stage.");

  a_normal_radius : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !radius_clamped_o) |-> (used_radius_o != '0)
  ) else $error("Unclamped arc reported with a zero radius.");

endmodule
